// ===== hw/rtl/ilb_pkg.sv =====
// Shared types, constants and helpers for the indexed list buffer.
package ilb_pkg;

  localparam int CAPACITY = 64;
  localparam int HANDLE_W = 32;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 7;
  localparam int ITEM_W  = 32;
  localparam int COUNT_W = 7;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_GET    = 2'd2,
    FN_REMOVE = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [ITEM_W-1:0]  item;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ITEM_W-1:0]  item_out;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic eval;
    logic wr_append;
    logic wr_insert;
    logic rd_get;
    logic get_capture;
    logic ptr_init;
    logic sh_rd;
    logic sh_wr;
    logic cnt_dec;
  } ilb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e_t op;
    logic    pre_ok;
    logic    idx_at_end;
    logic    sh_last;
  } ilb_sts_t;

  function automatic logic [HANDLE_W-1:0] to_handle(input logic [ITEM_W-1:0] item);
    logic [63:0] wide;
    wide = 64'(item);
    return wide[HANDLE_W-1:0];
  endfunction

  function automatic logic [ITEM_W-1:0] to_item_out(input logic [HANDLE_W-1:0] h);
    logic [63:0] wide;
    wide = 64'(h);
    return wide[ITEM_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/ilb_ctrl.sv =====
// Controller state machine: sequences each operation over the datapath.
module ilb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             slot_free,
  input  ilb_pkg::ilb_sts_t sts,
  output logic             in_ready,
  output logic             res_load,
  output ilb_pkg::ilb_cmd_t cmd
);
  import ilb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.pre_ok) begin
          state_next = S_FINISH;
        end else begin
          case (sts.op)
            FN_GET: state_next = S_GET_WAIT;
            FN_INSERT, FN_REMOVE: state_next = sts.idx_at_end ? S_FINISH : S_SH_RD;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_GET_WAIT: state_next = S_FINISH;
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: begin
        if (sts.sh_last) begin
          state_next = (sts.op == FN_INSERT) ? S_INS_WR : S_FINISH;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_INS_WR: state_next = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = req_valid;
      end
      S_EXEC: begin
        cmd.eval = 1'b1;
        if (sts.pre_ok) begin
          case (sts.op)
            FN_APPEND: cmd.wr_append = 1'b1;
            FN_INSERT: begin
              cmd.wr_insert = sts.idx_at_end;
              cmd.ptr_init  = !sts.idx_at_end;
            end
            FN_GET: cmd.rd_get = 1'b1;
            FN_REMOVE: begin
              cmd.cnt_dec  = sts.idx_at_end;
              cmd.ptr_init = !sts.idx_at_end;
            end
            default: cmd = '0;
          endcase
        end
      end
      S_GET_WAIT: cmd.get_capture = 1'b1;
      S_SH_RD: cmd.sh_rd = 1'b1;
      S_SH_WR: begin
        cmd.sh_wr   = 1'b1;
        cmd.cnt_dec = sts.sh_last && (sts.op == FN_REMOVE);
      end
      S_INS_WR: cmd.wr_insert = 1'b1;
      S_FINISH: res_load = slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ilb_dp.sv =====
// Datapath: entry memory, entry count, shift pointer and result fields.
module ilb_dp (
  input  logic             clk,
  input  logic             rst,
  input  ilb_pkg::req_t    req,
  input  ilb_pkg::ilb_cmd_t cmd,
  output ilb_pkg::ilb_sts_t sts,
  output ilb_pkg::rsp_t    result
);
  import ilb_pkg::*;

  logic [HANDLE_W-1:0] mem [CAPACITY];
  logic [HANDLE_W-1:0] rd_data;

  func_e_t             op;
  logic [INDEX_W-1:0]  idx;
  logic [HANDLE_W-1:0] item;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    ptr;
  status_e_t           res_status;
  logic [ITEM_W-1:0]   res_item;

  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] ptr_ext;
  logic             full;
  status_e_t        pre_status;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [HANDLE_W-1:0] wr_data;
  logic             up;

  assign cnt_ext = CMP_W'(cnt);
  assign idx_ext = CMP_W'(idx);
  assign ptr_ext = CMP_W'(ptr);
  assign full    = (cnt == CNT_W'(CAPACITY));
  assign up      = (op == FN_INSERT);

  always_comb begin
    pre_status = ST_OK;
    case (op)
      FN_APPEND: pre_status = full ? ST_FULL : ST_OK;
      FN_INSERT: begin
        if (idx_ext > cnt_ext) begin
          pre_status = ST_RANGE;
        end else if (full) begin
          pre_status = ST_FULL;
        end
      end
      FN_GET, FN_REMOVE: pre_status = (idx_ext >= cnt_ext) ? ST_RANGE : ST_OK;
      default: pre_status = ST_OK;
    endcase
  end

  assign sts.op         = op;
  assign sts.pre_ok     = (pre_status == ST_OK);
  assign sts.idx_at_end = up ? (idx_ext == cnt_ext) : (CMP_W'(idx_ext + 1'b1) == cnt_ext);
  assign sts.sh_last    = up ? (ptr_ext == CMP_W'(idx_ext + 1'b1))
                             : (CMP_W'(ptr_ext + 2'd2) == cnt_ext);

  // Read port: direct index for get, neighbor of the pointer while shifting.
  always_comb begin
    rd_en   = cmd.rd_get || cmd.sh_rd;
    rd_addr = idx_ext[IDX_W-1:0];
    if (cmd.sh_rd) begin
      rd_addr = up ? IDX_W'(ptr - 1'b1) : IDX_W'(ptr + 1'b1);
    end
  end

  always_comb begin
    wr_en   = cmd.wr_append || cmd.wr_insert || cmd.sh_wr;
    wr_addr = cnt[IDX_W-1:0];
    wr_data = item;
    if (cmd.wr_insert) begin
      wr_addr = idx_ext[IDX_W-1:0];
    end else if (cmd.sh_wr) begin
      wr_addr = ptr[IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.wr_append || cmd.wr_insert) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op   <= func_e_t'(req.func);
      idx  <= req.index;
      item <= to_handle(req.item);
    end
    if (cmd.ptr_init) begin
      ptr <= up ? cnt : CNT_W'(idx_ext);
    end else if (cmd.sh_wr) begin
      ptr <= up ? ptr - 1'b1 : ptr + 1'b1;
    end
    if (cmd.eval) begin
      res_status <= pre_status;
      res_item   <= '0;
    end else if (cmd.get_capture) begin
      res_item <= to_item_out(rd_data);
    end
  end

  assign result.status   = res_status;
  assign result.item_out = res_item;
  assign result.count    = COUNT_W'(cnt);

endmodule

// ===== hw/rtl/indexed_list_buffer_unit.sv =====
// Indexed list buffer top level: request channel, result register, checks.
//
// Usage: an ordered list of handles packed from position 0. Send one request
// transaction on req (func, index, item); one result transaction comes back
// on rsp (status, item_out, count), in request order. Status 0 is ok,
// 1 index out of range, 2 list full; count is the entry count afterwards.
// One request is in work at a time; req_ready is high only while idle.
// An accepted request is checked first: append writes its item there, any
// error ends there, get reads the entry memory, and insert or remove first
// move the entries behind the index, an insert then writing the new item.
// Each moved entry is read and then written back in the entry memory. A new
// request can be taken in the cycle after the previous result is loaded,
// even while that result still waits in the output register.
// Reset clears the entry count and empties the output register; the entry
// memory itself is not cleared. If the receiver stalls, the result holds in
// the output register and the next finished result waits inside the block.
module indexed_list_buffer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ilb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ilb_pkg::rsp_t rsp
);
  import ilb_pkg::*;

  ilb_cmd_t cmd;
  ilb_sts_t sts;
  rsp_t     result;
  logic     slot_free;
  logic     res_load;

  assign slot_free = !rsp_valid || rsp_ready;

  ilb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .slot_free (slot_free),
    .sts       (sts),
    .in_ready  (req_ready),
    .res_load  (res_load),
    .cmd       (cmd)
  );

  ilb_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= result;
    end
  end

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a transaction is in work");

  a_error_item_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.item_out == '0))
    else $error("failed transaction returned a nonzero handle");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> (rsp.count == COUNT_W'(CAPACITY)))
    else $error("list full reported below capacity");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CMP_W'(rsp.count) <= CMP_W'(CAPACITY)))
    else $error("entry count exceeds capacity");

endmodule
